>>> hw/rtl/rpn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg
// Opcodes, tags and error codes of the postfix stack machine.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam logic [4:0] OP_PUSH_NUM = 5'd0;
	localparam logic [4:0] OP_PUSH_VAR = 5'd1;
	localparam logic [4:0] OP_PUSH_LBL = 5'd2;
	localparam logic [4:0] OP_ADD      = 5'd3;
	localparam logic [4:0] OP_SUB      = 5'd4;
	localparam logic [4:0] OP_MUL      = 5'd5;
	localparam logic [4:0] OP_DIV      = 5'd6;
	localparam logic [4:0] OP_LT       = 5'd7;
	localparam logic [4:0] OP_GT       = 5'd8;
	localparam logic [4:0] OP_LE       = 5'd9;
	localparam logic [4:0] OP_GE       = 5'd10;
	localparam logic [4:0] OP_EQ       = 5'd11;
	localparam logic [4:0] OP_NE       = 5'd12;
	localparam logic [4:0] OP_AND      = 5'd13;
	localparam logic [4:0] OP_OR       = 5'd14;
	localparam logic [4:0] OP_NOT      = 5'd15;
	localparam logic [4:0] OP_ASSIGN   = 5'd16;
	localparam logic [4:0] OP_JUMP     = 5'd17;
	localparam logic [4:0] OP_JZ       = 5'd18;
	localparam logic [4:0] OP_OUTPUT   = 5'd19;
	localparam logic [4:0] OP_DECLARE  = 5'd20;

	localparam logic [1:0] TAG_NUM = 2'd0;
	localparam logic [1:0] TAG_VAR = 2'd1;
	localparam logic [1:0] TAG_LBL = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_UNDERFLOW  = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd2;
	localparam logic [2:0] ERR_UNDECLARED = 3'd3;
	localparam logic [2:0] ERR_REDECLARED = 3'd4;
	localparam logic [2:0] ERR_DIV_ZERO   = 3'd5;
	localparam logic [2:0] ERR_BAD_JUMP   = 3'd6;
	localparam logic [2:0] ERR_NOT_VAR    = 3'd7;

	typedef struct packed {
		logic [1:0]  tag;
		logic [31:0] val;
	} entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/rpn_stack_machine_executor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_machine_executor
// Postfix stack machine: one instruction per input beat, one result beat.
// Pushes, unused opcodes and halted steps go from S_RDB straight to S_DONE;
// other ops read one or two stack entries and variables, then run S_EXEC,
// plus S_MUL for mul or the 32-step serial divider for div; an error cuts the
// sequence short. One instruction at a time: a new one is taken only after
// the result beat is accepted. Memories have registered reads and are not
// cleared at reset. Reset clears pointers, error, halt and declared bits.
// ----------------------------------------------------------------------------
module rpn_stack_machine_executor #(
	parameter int STACK_DEPTH    = 64,
	parameter int VARIABLE_COUNT = 64,
	parameter int PROGRAM_DEPTH  = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  opcode,
	input  wire logic signed [31:0] immediate_value,
	input  wire logic [5:0]  variable_slot,
	input  wire logic [11:0] label_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      next_address,
	output logic             output_valid,
	output logic signed [31:0] output_value,
	output logic [2:0]       error_code,
	output logic             halted
);

	localparam int SPW = $clog2(STACK_DEPTH);
	localparam int VW  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RDB, S_WB, S_RDA, S_WA, S_VARB, S_VARA, S_EXEC, S_MUL, S_DIV,
		S_DIVF, S_DONE, S_OUT
	} state_t;

	state_t state_q;

	rpn_pkg::entry_t stack_mem [STACK_DEPTH];
	logic [31:0]     var_mem   [VARIABLE_COUNT];
	logic [VARIABLE_COUNT-1:0] decl_q;

	logic [SPW:0]  sp_q;
	logic [11:0]   ip_q;
	logic          halt_q;
	logic [2:0]    err_q;

	logic [4:0]    op_q;
	logic [31:0]   imm_q;
	logic [5:0]    slot_q;
	logic [11:0]   lbl_q;

	rpn_pkg::entry_t srd_q;
	logic [31:0]     vrd_q;
	rpn_pkg::entry_t ea_q, eb_q;
	logic [31:0]     x_q, y_q;
	logic [11:0]     nxt_q;
	logic            ov_q;
	logic [31:0]     oval_q;

	logic [31:0]     mul_q;
	logic [31:0]     quo_q, rem_q, dvd_q, dvs_q;
	logic [5:0]      cnt_q;
	logic            neg_q;

	// stack and variable memory access
	logic            s_we;
	logic [SPW-1:0]  s_addr;
	rpn_pkg::entry_t s_wd;
	logic            v_we;
	logic [VW-1:0]   v_addr;
	logic [31:0]     v_wd;

	always_ff @(posedge clk) begin
		if (s_we) begin
			stack_mem[s_addr] <= s_wd;
		end
		srd_q <= stack_mem[s_addr];
		if (v_we) begin
			var_mem[v_addr] <= v_wd;
		end
		vrd_q <= var_mem[v_addr];
	end

	function automatic logic var_ok(input rpn_pkg::entry_t e,
		input logic [VARIABLE_COUNT-1:0] d);
		logic ok;
		ok = 1'b0;
		if (e.val < 32'(VARIABLE_COUNT)) begin
			ok = d[e.val[VW-1:0]];
		end
		return ok;
	endfunction

	logic [11:0] ip_inc;
	assign ip_inc = (32'(ip_q) + 32'd1 >= 32'(PROGRAM_DEPTH)) ? 12'd0 : ip_q + 12'd1;

	logic is_bin, two_ops, pop_b_res, is_push;
	assign is_push = op_q == rpn_pkg::OP_PUSH_NUM || op_q == rpn_pkg::OP_PUSH_VAR
		|| op_q == rpn_pkg::OP_PUSH_LBL;
	assign is_bin  = op_q >= rpn_pkg::OP_ADD && op_q <= rpn_pkg::OP_OR;
	assign two_ops = is_bin || op_q == rpn_pkg::OP_ASSIGN || op_q == rpn_pkg::OP_JZ;
	assign pop_b_res = is_bin || op_q == rpn_pkg::OP_ASSIGN;

	// shared ALU
	logic [31:0] alu;
	always_comb begin
		case (op_q)
			rpn_pkg::OP_ADD: alu = x_q + y_q;
			rpn_pkg::OP_SUB: alu = x_q - y_q;
			rpn_pkg::OP_LT:  alu = {31'd0, $signed(x_q) <  $signed(y_q)};
			rpn_pkg::OP_GT:  alu = {31'd0, $signed(x_q) >  $signed(y_q)};
			rpn_pkg::OP_LE:  alu = {31'd0, $signed(x_q) <= $signed(y_q)};
			rpn_pkg::OP_GE:  alu = {31'd0, $signed(x_q) >= $signed(y_q)};
			rpn_pkg::OP_EQ:  alu = {31'd0, x_q == y_q};
			rpn_pkg::OP_NE:  alu = {31'd0, x_q != y_q};
			rpn_pkg::OP_AND: alu = {31'd0, (x_q != 0) && (y_q != 0)};
			rpn_pkg::OP_OR:  alu = {31'd0, (x_q != 0) || (y_q != 0)};
			rpn_pkg::OP_NOT: alu = {31'd0, x_q == 0};
			default:         alu = x_q;
		endcase
	end

	logic [32:0] rem_sh;
	assign rem_sh = {rem_q, dvd_q[31]} - {1'b0, dvs_q};

	always_comb begin
		s_we   = 1'b0;
		s_addr = sp_q[SPW-1:0];
		s_wd   = '0;
		v_we   = 1'b0;
		v_addr = '0;
		v_wd   = '0;
		case (state_q)
			S_IDLE: s_addr = sp_q[SPW-1:0] - SPW'(1);
			S_RDB:  s_addr = sp_q[SPW-1:0] - SPW'(1);
			S_WB:   s_addr = sp_q[SPW-1:0] - SPW'(2);
			S_RDA:  s_addr = sp_q[SPW-1:0] - SPW'(2);
			S_WA:   v_addr = eb_q.val[VW-1:0];
			S_VARB: v_addr = ea_q.val[VW-1:0];
			S_DONE: begin
				s_addr = sp_q[SPW-1:0];
				if (is_push && sp_q < (SPW+1)'(STACK_DEPTH)) begin
					s_we = 1'b1;
					case (op_q)
						rpn_pkg::OP_PUSH_NUM: s_wd = {rpn_pkg::TAG_NUM, imm_q};
						rpn_pkg::OP_PUSH_VAR: s_wd = {rpn_pkg::TAG_VAR, 26'd0, slot_q};
						default:              s_wd = {rpn_pkg::TAG_LBL, 20'd0, lbl_q};
					endcase
				end else if (err_q == rpn_pkg::ERR_NONE && !halt_q
					&& (is_bin || op_q == rpn_pkg::OP_NOT)) begin
					s_we = 1'b1;
					s_wd = {rpn_pkg::TAG_NUM, x_q};
				end
				v_addr = ea_q.val[VW-1:0];
				if (err_q == rpn_pkg::ERR_NONE && !halt_q) begin
					if (op_q == rpn_pkg::OP_ASSIGN) begin
						v_we = 1'b1;
						v_wd = y_q;
					end else if (op_q == rpn_pkg::OP_DECLARE) begin
						v_we = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			ip_q      <= '0;
			halt_q    <= 1'b0;
			err_q     <= rpn_pkg::ERR_NONE;
			decl_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						imm_q  <= immediate_value;
						slot_q <= variable_slot;
						lbl_q  <= label_address;
						ov_q   <= 1'b0;
						oval_q <= '0;
						state_q <= S_RDB;
					end
				end
				S_RDB: begin
					nxt_q <= ip_inc;
					if (halt_q || is_push || op_q > rpn_pkg::OP_DECLARE) begin
						state_q <= S_DONE;
					end else if (two_ops ? sp_q < (SPW+1)'(2) : sp_q < (SPW+1)'(1)) begin
						halt_q <= 1'b1;
						err_q <= rpn_pkg::ERR_UNDERFLOW;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (two_ops) begin
						eb_q <= srd_q;
						state_q <= S_RDA;
					end else begin
						ea_q <= srd_q;
						eb_q <= srd_q;
						sp_q <= sp_q - (SPW+1)'(1);
						state_q <= S_WA;
					end
				end
				S_RDA: begin
					ea_q <= srd_q;
					sp_q <= sp_q - (SPW+1)'(2);
					state_q <= S_WA;
				end
				S_WA: state_q <= S_VARB;
				S_VARB: begin
					// vrd_q holds var(eb)
					state_q <= S_VARA;
					if (pop_b_res || op_q == rpn_pkg::OP_NOT || op_q == rpn_pkg::OP_OUTPUT)
					begin
						if (eb_q.tag == rpn_pkg::TAG_VAR) begin
							if (!var_ok(eb_q, decl_q)) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_UNDECLARED;
								state_q <= S_DONE;
							end
							y_q <= vrd_q;
							x_q <= vrd_q;
						end else begin
							y_q <= eb_q.val;
							x_q <= eb_q.val;
						end
					end
				end
				S_VARA: begin
					state_q <= S_EXEC;
					if (is_bin || op_q == rpn_pkg::OP_JZ) begin
						if (op_q == rpn_pkg::OP_JZ && (eb_q.tag == rpn_pkg::TAG_VAR
							|| eb_q.val >= 32'(PROGRAM_DEPTH))) begin
							halt_q <= 1'b1;
							err_q <= rpn_pkg::ERR_BAD_JUMP;
							state_q <= S_DONE;
						end else if (ea_q.tag == rpn_pkg::TAG_VAR) begin
							if (!var_ok(ea_q, decl_q)) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_UNDECLARED;
								state_q <= S_DONE;
							end
							x_q <= vrd_q;
						end else begin
							x_q <= ea_q.val;
						end
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q)
						rpn_pkg::OP_MUL: begin
							mul_q <= x_q * y_q;
							state_q <= S_MUL;
						end
						rpn_pkg::OP_DIV: begin
							if (y_q == 0) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_DIV_ZERO;
							end else begin
								dvd_q <= x_q[31] ? -x_q : x_q;
								dvs_q <= y_q[31] ? -y_q : y_q;
								neg_q <= x_q[31] ^ y_q[31];
								rem_q <= '0;
								quo_q <= '0;
								cnt_q <= 6'd32;
								state_q <= S_DIV;
							end
						end
						rpn_pkg::OP_ASSIGN: begin
							if (ea_q.tag != rpn_pkg::TAG_VAR) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_NOT_VAR;
							end else if (!var_ok(ea_q, decl_q)) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_UNDECLARED;
							end
						end
						rpn_pkg::OP_JUMP: begin
							if (ea_q.tag == rpn_pkg::TAG_VAR
								|| ea_q.val >= 32'(PROGRAM_DEPTH)) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_BAD_JUMP;
							end else begin
								nxt_q <= ea_q.val[11:0];
							end
						end
						rpn_pkg::OP_JZ: begin
							if (x_q == 0) begin
								nxt_q <= eb_q.val[11:0];
							end
						end
						rpn_pkg::OP_OUTPUT: begin
							ov_q <= 1'b1;
							oval_q <= x_q;
						end
						rpn_pkg::OP_DECLARE: begin
							if (ea_q.tag != rpn_pkg::TAG_VAR) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_NOT_VAR;
							end else if (ea_q.val >= 32'(VARIABLE_COUNT)) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_UNDECLARED;
							end else if (decl_q[ea_q.val[VW-1:0]]) begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_REDECLARED;
							end
						end
						default: x_q <= alu;
					endcase
				end
				S_MUL: begin
					x_q <= mul_q;
					state_q <= S_DONE;
				end
				S_DIV: begin
					dvd_q <= {dvd_q[30:0], 1'b0};
					if (!rem_sh[32]) begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], dvd_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= S_DIVF;
					end
				end
				S_DIVF: begin
					x_q <= neg_q ? -quo_q : quo_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!halt_q) begin
						if (is_push) begin
							if (sp_q < (SPW+1)'(STACK_DEPTH)) begin
								sp_q <= sp_q + (SPW+1)'(1);
								ip_q <= nxt_q;
							end else begin
								halt_q <= 1'b1;
								err_q <= rpn_pkg::ERR_OVERFLOW;
								ov_q <= 1'b0;
							end
						end else begin
							ip_q <= nxt_q;
							if (is_bin || op_q == rpn_pkg::OP_NOT) begin
								sp_q <= sp_q + (SPW+1)'(1);
							end
							if (op_q == rpn_pkg::OP_DECLARE) begin
								decl_q[ea_q.val[VW-1:0]] <= 1'b1;
							end
						end
					end else begin
						ov_q <= 1'b0;
						oval_q <= '0;
					end
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = state_q != S_IDLE;
	assign next_address = ip_q;
	assign output_valid = ov_q & ~halt_q;
	assign output_value = halt_q ? 32'sd0 : oval_q;
	assign error_code   = err_q;
	assign halted       = halt_q;

endmodule
`default_nettype wire

>>> bench/rpn_stack_machine_executor_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_machine_executor_tb
// Drives directed and random postfix programs into the stack machine, with
// random gaps on both sides, and checks every result beat against a
// predictor of the machine or, for some directed rows, fixed values.
// The run ends with one faulting sequence and a few beats while halted.
// ----------------------------------------------------------------------------
module rpn_stack_machine_executor_tb;

	typedef struct {
		logic [4:0]  op;
		logic [31:0] imm;
		logic [5:0]  slot;
		logic [11:0] lbl;
	} instr_t;

	typedef struct {
		logic [11:0] nxt;
		logic        ov;
		logic [31:0] val;
		logic [2:0]  err;
		logic        hlt;
	} res_t;

	typedef struct {
		logic [4:0]  op;
		logic [31:0] imm;
		logic [5:0]  slot;
		logic [11:0] lbl;
		bit          typed;
		res_t        exp;
	} row_t;

	localparam int DEPTH = 64;
	localparam int SLOTS = 64;
	localparam int N_RANDOM = 1750;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [4:0] opcode = '0;
	logic signed [31:0] immediate_value = '0;
	logic [5:0] variable_slot = '0;
	logic [11:0] label_address = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [11:0] next_address;
	logic output_valid;
	logic signed [31:0] output_value;
	logic [2:0] error_code;
	logic halted;

	// machine image kept by the predictor
	logic [1:0]  stk_tag [DEPTH];
	logic [31:0] stk_val [DEPTH];
	int          depth_q = 0;
	logic [31:0] var_val [SLOTS];
	bit          var_decl [SLOTS];
	logic [11:0] ip_q = '0;
	logic        halt_q = 0;
	logic [2:0]  serr_q = rpn_pkg::ERR_NONE;

	instr_t program_q[$];
	res_t   pending_results[$];
	int     errors = 0;
	int     cycles = 0;
	bit     calm = 0;

	rpn_stack_machine_executor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .immediate_value(immediate_value),
		.variable_slot(variable_slot), .label_address(label_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_address(next_address), .output_valid(output_valid),
		.output_value(output_value), .error_code(error_code), .halted(halted)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [2:0] resolve(logic [1:0] tag, logic [31:0] v,
			output logic [31:0] r);
		r = v;
		if (tag == rpn_pkg::TAG_VAR) begin
			if (!var_decl[v[5:0]])
				return rpn_pkg::ERR_UNDECLARED;
			r = var_val[v[5:0]];
		end
		return rpn_pkg::ERR_NONE;
	endfunction

	function automatic logic [2:0] push_entry(logic [1:0] tag, logic [31:0] v);
		if (depth_q >= DEPTH)
			return rpn_pkg::ERR_OVERFLOW;
		stk_tag[depth_q] = tag;
		stk_val[depth_q] = v;
		depth_q++;
		return rpn_pkg::ERR_NONE;
	endfunction

	function automatic logic [31:0] top_value();
		logic [31:0] v;
		void'(resolve(stk_tag[depth_q-1], stk_val[depth_q-1], v));
		return v;
	endfunction

	task automatic execute_instr(input instr_t i, output res_t r);
		logic [11:0] nxt;
		logic ov;
		logic [31:0] oval, x, y, t;
		logic signed [31:0] sx, sy;
		logic [2:0] e;
		logic [1:0] atag, btag;
		logic [31:0] aval, bval;
		int need;
		ov = 0;
		oval = '0;
		if (!halt_q) begin
			nxt = ip_q + 12'd1;
			e = rpn_pkg::ERR_NONE;
			if (i.op == rpn_pkg::OP_PUSH_NUM) begin
				e = push_entry(rpn_pkg::TAG_NUM, i.imm);
			end else if (i.op == rpn_pkg::OP_PUSH_VAR) begin
				e = push_entry(rpn_pkg::TAG_VAR, {26'd0, i.slot});
			end else if (i.op == rpn_pkg::OP_PUSH_LBL) begin
				e = push_entry(rpn_pkg::TAG_LBL, {20'd0, i.lbl});
			end else if (i.op <= rpn_pkg::OP_DECLARE) begin
				need = (i.op <= rpn_pkg::OP_OR || i.op == rpn_pkg::OP_ASSIGN
					|| i.op == rpn_pkg::OP_JZ) ? 2 : 1;
				if (depth_q < need) begin
					e = rpn_pkg::ERR_UNDERFLOW;
				end else begin
					if (need == 2) begin
						depth_q--;
						btag = stk_tag[depth_q];
						bval = stk_val[depth_q];
					end
					depth_q--;
					atag = stk_tag[depth_q];
					aval = stk_val[depth_q];
					if (i.op <= rpn_pkg::OP_OR) begin
						e = resolve(btag, bval, y);
						if (e == rpn_pkg::ERR_NONE) e = resolve(atag, aval, x);
						if (e == rpn_pkg::ERR_NONE) begin
							sx = x;
							sy = y;
							t = '0;
							case (i.op)
								rpn_pkg::OP_ADD: t = x + y;
								rpn_pkg::OP_SUB: t = x - y;
								rpn_pkg::OP_MUL: t = x * y;
								rpn_pkg::OP_DIV: begin
									if (y == 0) e = rpn_pkg::ERR_DIV_ZERO;
									else if (x == 32'h8000_0000 && y == '1) t = x;
									else t = sx / sy;
								end
								rpn_pkg::OP_LT: t = {31'd0, sx < sy};
								rpn_pkg::OP_GT: t = {31'd0, sx > sy};
								rpn_pkg::OP_LE: t = {31'd0, sx <= sy};
								rpn_pkg::OP_GE: t = {31'd0, sx >= sy};
								rpn_pkg::OP_EQ: t = {31'd0, x == y};
								rpn_pkg::OP_NE: t = {31'd0, x != y};
								rpn_pkg::OP_AND: t = {31'd0, (x != 0) && (y != 0)};
								default: t = {31'd0, (x != 0) || (y != 0)};
							endcase
							if (e == rpn_pkg::ERR_NONE) e = push_entry(rpn_pkg::TAG_NUM, t);
						end
					end else begin
						case (i.op)
							rpn_pkg::OP_NOT: begin
								e = resolve(atag, aval, x);
								if (e == rpn_pkg::ERR_NONE)
									e = push_entry(rpn_pkg::TAG_NUM, {31'd0, x == 0});
							end
							rpn_pkg::OP_ASSIGN: begin
								e = resolve(btag, bval, y);
								if (e == rpn_pkg::ERR_NONE && atag != rpn_pkg::TAG_VAR)
									e = rpn_pkg::ERR_NOT_VAR;
								if (e == rpn_pkg::ERR_NONE && !var_decl[aval[5:0]])
									e = rpn_pkg::ERR_UNDECLARED;
								if (e == rpn_pkg::ERR_NONE) var_val[aval[5:0]] = y;
							end
							rpn_pkg::OP_JUMP: begin
								if (atag == rpn_pkg::TAG_VAR || aval >= 4096)
									e = rpn_pkg::ERR_BAD_JUMP;
								else nxt = aval[11:0];
							end
							rpn_pkg::OP_JZ: begin
								if (btag == rpn_pkg::TAG_VAR || bval >= 4096)
									e = rpn_pkg::ERR_BAD_JUMP;
								if (e == rpn_pkg::ERR_NONE) e = resolve(atag, aval, x);
								if (e == rpn_pkg::ERR_NONE && x == 0) nxt = bval[11:0];
							end
							rpn_pkg::OP_OUTPUT: begin
								e = resolve(atag, aval, x);
								if (e == rpn_pkg::ERR_NONE) begin
									ov = 1;
									oval = x;
								end
							end
							default: begin
								if (atag != rpn_pkg::TAG_VAR) e = rpn_pkg::ERR_NOT_VAR;
								else if (var_decl[aval[5:0]]) e = rpn_pkg::ERR_REDECLARED;
								else begin
									var_decl[aval[5:0]] = 1;
									var_val[aval[5:0]] = '0;
								end
							end
						endcase
					end
				end
			end
			if (e != rpn_pkg::ERR_NONE) begin
				halt_q = 1;
				serr_q = e;
				ov = 0;
				oval = '0;
			end else begin
				ip_q = nxt;
			end
		end
		r = '{ip_q, ov, oval, serr_q, halt_q};
	endtask

	task automatic emit(logic [4:0] op, logic [31:0] imm, logic [5:0] slot,
			logic [11:0] lbl);
		instr_t i;
		res_t r;
		i = '{op, imm, slot, lbl};
		execute_instr(i, r);
		program_q.push_back(i);
		pending_results.push_back(r);
	endtask

	task automatic emit_num(logic [31:0] v);
		emit(rpn_pkg::OP_PUSH_NUM, v, 6'($urandom), 12'($urandom));
	endtask

	task automatic emit_var(logic [5:0] s);
		emit(rpn_pkg::OP_PUSH_VAR, $urandom, s, 12'($urandom));
	endtask

	task automatic emit_lbl(logic [11:0] a);
		emit(rpn_pkg::OP_PUSH_LBL, $urandom, 6'($urandom), a);
	endtask

	task automatic emit_op(logic [4:0] op);
		emit(op, $urandom, 6'($urandom), 12'($urandom));
	endtask

	function automatic int pick_slot(bit declared);
		int s;
		s = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			if (var_decl[(s + k) % SLOTS] == declared)
				return (s + k) % SLOTS;
		end
		return -1;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3, 4: return 32'd0;
			5, 6: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	task automatic build_directed();
		row_t rows [$];
		instr_t i;
		res_t r;
		rows = '{
			'{rpn_pkg::OP_PUSH_NUM, 32'h7fff_ffff, 6'd0, 12'd0, 1,
				'{12'd1, 0, 0, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'h8000_0000, 6'h3f, 12'hfff, 0, '{default: 0}},
			'{rpn_pkg::OP_ADD, 32'd0, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_OUTPUT, 32'd0, 6'd0, 12'd0, 1,
				'{12'd4, 1, 32'hffff_ffff, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_VAR, 32'd0, 6'h3f, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_DECLARE, 32'd0, 6'd0, 12'd0, 1,
				'{12'd6, 0, 0, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_VAR, 32'd0, 6'h3f, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'd5, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_ASSIGN, 32'd0, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_PUSH_VAR, 32'd0, 6'h3f, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_OUTPUT, 32'd0, 6'd0, 12'd0, 1,
				'{12'd11, 1, 32'd5, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'h8000_0000, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'hffff_ffff, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_DIV, 32'd0, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_OUTPUT, 32'd0, 6'd0, 12'd0, 1,
				'{12'd15, 1, 32'h8000_0000, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_LBL, 32'd0, 6'd0, 12'hfff, 0, '{default: 0}},
			'{rpn_pkg::OP_JUMP, 32'd0, 6'd0, 12'd0, 1,
				'{12'hfff, 0, 0, rpn_pkg::ERR_NONE, 0}},
			'{5'd31, 32'hffff_ffff, 6'h3f, 12'hfff, 1,
				'{12'd0, 0, 0, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'd0, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_PUSH_LBL, 32'd0, 6'd0, 12'd40, 0, '{default: 0}},
			'{rpn_pkg::OP_JZ, 32'd0, 6'd0, 12'd0, 1,
				'{12'd40, 0, 0, rpn_pkg::ERR_NONE, 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'hffff_fffd, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_PUSH_NUM, 32'd7, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_MUL, 32'd0, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_NOT, 32'd0, 6'd0, 12'd0, 0, '{default: 0}},
			'{rpn_pkg::OP_OUTPUT, 32'd0, 6'd0, 12'd0, 0, '{default: 0}}
		};
		foreach (rows[n]) begin
			i = '{rows[n].op, rows[n].imm, rows[n].slot, rows[n].lbl};
			execute_instr(i, r);
			program_q.push_back(i);
			pending_results.push_back(rows[n].typed ? rows[n].exp : r);
		end
	endtask

	task automatic build_random();
		int r, s;
		logic [4:0] op;
		while (program_q.size() < N_RANDOM) begin
			r = $urandom_range(0, 99);
			s = -1;
			if (r < 3) begin
				emit_op(5'($urandom_range(21, 31)));
				continue;
			end
			if (depth_q > 58) begin
				emit_op($urandom_range(0, 1) ? rpn_pkg::OP_OUTPUT : rpn_pkg::OP_NOT);
			end else if (depth_q < 2 || r < 33) begin
				case ($urandom_range(0, 3))
					0: emit_lbl(12'($urandom));
					1: begin
						s = pick_slot(1);
						if (s >= 0) emit_var(6'(s));
						else emit_num(pick_value());
					end
					default: emit_num(pick_value());
				endcase
			end else if (r < 70) begin
				op = 5'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_OR));
				if (op == rpn_pkg::OP_DIV && top_value() == 0)
					op = rpn_pkg::OP_SUB;
				emit_op(op);
			end else if (r < 76) begin
				emit_op(rpn_pkg::OP_NOT);
			end else if (r < 82) begin
				emit_op(rpn_pkg::OP_OUTPUT);
			end else if (r < 86) begin
				s = pick_slot(0);
				if (s >= 0) begin
					emit_var(6'(s));
					emit_op(rpn_pkg::OP_DECLARE);
				end else begin
					emit_op(rpn_pkg::OP_OUTPUT);
				end
			end else if (r < 92) begin
				s = pick_slot(1);
				if (s >= 0) begin
					emit_var(6'(s));
					emit_num(pick_value());
					emit_op(rpn_pkg::OP_ASSIGN);
				end else begin
					emit_op(rpn_pkg::OP_OUTPUT);
				end
			end else if (r < 95) begin
				if ($urandom_range(0, 1)) emit_lbl(12'($urandom));
				else emit_num($urandom_range(0, 4095));
				emit_op(rpn_pkg::OP_JUMP);
			end else begin
				emit_num($urandom_range(0, 2) == 0 ? $urandom : 32'd0);
				emit_lbl(12'($urandom));
				emit_op(rpn_pkg::OP_JZ);
			end
		end
	endtask

	task automatic build_fault();
		int kind, s;
		kind = $urandom_range(rpn_pkg::ERR_UNDERFLOW, rpn_pkg::ERR_NOT_VAR);
		while (depth_q > 60)
			emit_op(rpn_pkg::OP_OUTPUT);
		if (kind == rpn_pkg::ERR_UNDECLARED && pick_slot(0) < 0)
			kind = rpn_pkg::ERR_NOT_VAR;
		case (kind)
			rpn_pkg::ERR_UNDERFLOW: begin
				while (depth_q > 0)
					emit_op(rpn_pkg::OP_OUTPUT);
				emit_op(rpn_pkg::OP_ADD);
			end
			rpn_pkg::ERR_OVERFLOW: begin
				while (depth_q < DEPTH)
					emit_num($urandom);
				emit_num($urandom);
			end
			rpn_pkg::ERR_UNDECLARED: begin
				emit_var(6'(pick_slot(0)));
				emit_op(rpn_pkg::OP_OUTPUT);
			end
			rpn_pkg::ERR_REDECLARED: begin
				s = pick_slot(1);
				if (s < 0) begin
					s = pick_slot(0);
					emit_var(6'(s));
					emit_op(rpn_pkg::OP_DECLARE);
				end
				emit_var(6'(s));
				emit_op(rpn_pkg::OP_DECLARE);
			end
			rpn_pkg::ERR_DIV_ZERO: begin
				emit_num($urandom);
				emit_num(32'd0);
				emit_op(rpn_pkg::OP_DIV);
			end
			rpn_pkg::ERR_BAD_JUMP: begin
				if ($urandom_range(0, 1)) emit_var(6'($urandom));
				else emit_num($urandom_range(4096, 32'hffff_ffff));
				emit_op(rpn_pkg::OP_JUMP);
			end
			default: begin
				emit_num($urandom);
				emit_op(rpn_pkg::OP_DECLARE);
			end
		endcase
		repeat (8)
			emit(5'($urandom_range(0, 31)), $urandom, 6'($urandom), 12'($urandom));
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch on %s: got %h, expected %h", what, got, exp);
		errors++;
	endtask

	initial begin
		int gap, n;
		instr_t i;
		for (int k = 0; k < SLOTS; k++)
			var_decl[k] = 0;
		build_directed();
		build_random();
		build_fault();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		n = 0;
		while (program_q.size() > 0) begin
			i = program_q.pop_front();
			if (n % 200 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = pick_gap();
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			in_valid <= 1;
			opcode <= i.op;
			immediate_value <= i.imm;
			variable_slot <= i.slot;
			label_address <= i.lbl;
			do @(posedge clk); while (in_stall);
			n++;
		end
		@(negedge clk);
		in_valid <= 0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("rpn_stack_machine_executor test passed");
		else
			$display("rpn_stack_machine_executor test failed");
		$finish;
	end

	int hold = 0;
	always @(negedge clk) begin
		if (hold > 0) begin
			hold <= hold - 1;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			out_stall <= 1;
			hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rpn_stack_machine_executor test failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result beat", 32'd1, 32'd0);
			end else begin
				e = pending_results.pop_front();
				if (next_address !== e.nxt)
					report("next_address", 32'(next_address), 32'(e.nxt));
				if (output_valid !== e.ov)
					report("output_valid", 32'(output_valid), 32'(e.ov));
				if (output_value !== e.val)
					report("output_value", output_value, e.val);
				if (error_code !== e.err)
					report("error_code", 32'(error_code), 32'(e.err));
				if (halted !== e.hlt)
					report("halted", 32'(halted), 32'(e.hlt));
			end
		end
	end

endmodule
`default_nettype wire
